/* hdl/assert_macros.svh */
// assertion macros for the traversal engine rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define GTB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define GTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/gtb_pkg.sv */
// package: widths, codes and sequencer states of the graph traversal engine
package gtb_pkg;

	localparam int MAX_VERTICES_DEF = 64;

	localparam int VERTEX_W  = 6;
	localparam int OPCODE_W  = 2;
	localparam int S_DATA_W  = 16;
	localparam int M_DATA_W  = 8;
	localparam int M_USER_W  = 2;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	localparam logic [APB_AW-1:0] REG_MODE_ADDR = 3'd0;

	typedef enum logic [OPCODE_W-1:0] {
		OP_ADD_EDGE = 2'd0,
		OP_START    = 2'd1,
		OP_NEXT     = 2'd2,
		OP_CLEAR    = 2'd3
	} opcode_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_EDGE = 6'b000010,
		ST_POP  = 6'b000100,
		ST_ROW  = 6'b001000,
		ST_SCAN = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

endpackage

/* hdl/graph_traversal_bfs_dfs.sv */
// top level: breadth/depth first traversal engine over an adjacency bit matrix
//
// input stream (s_*): one transaction per command; s_tuser carries the opcode
// (add edge, start, next, clear), s_tdata the source/root and destination.
// output stream (m_*): one transaction per next command with the visited
// vertex, has_more and empty_error. other commands produce nothing.
// apb port: register 0 at address 0 holds traversal_mode (0 bfs, 1 dfs).
// start and clear finish in the idle state; add edge adds the edge state
// (row read-modify-write). a next command runs pop, row, scan and emit,
// the emit state loading the result register. the scan state pushes newly
// found successors one per cycle via the shared lowest-set-bit encoder. an
// empty frontier goes straight to emit, which loads the error result.
// one command at a time: s_tready is high only while the sequencer idles.
// the result sits in an output register; a stalled receiver holds the
// sequencer in its emit state until that register frees up.
// reset: no edges (row valid bits cleared), empty visited set and frontier,
// bfs mode. clear drops all row valid bits together, no sweep.
// the frontier store is never cleared; only entries pushed since the last
// start are read.
`include "assert_macros.svh"

module graph_traversal_bfs_dfs #(
	parameter int MAX_VERTICES = gtb_pkg::MAX_VERTICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [gtb_pkg::S_DATA_W-1:0]  s_tdata,   // src_vertex[5:0], dst_vertex[11:6]
	input  logic [gtb_pkg::OPCODE_W-1:0]  s_tuser,   // opcode[1:0]
	// output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [gtb_pkg::M_DATA_W-1:0]  m_tdata,   // vertex[5:0]
	output logic [gtb_pkg::M_USER_W-1:0]  m_tuser,   // has_more[0], empty_error[1]
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gtb_pkg::APB_AW-1:0]    paddr,
	input  logic [gtb_pkg::APB_DW-1:0]    pwdata,
	output logic [gtb_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);
	import gtb_pkg::*;

	localparam int VAW = $clog2(MAX_VERTICES);       // vertex index bits
	localparam int PW  = $clog2(MAX_VERTICES + 1);   // frontier pointer bits
	localparam logic [VERTEX_W:0] VLIM = (VERTEX_W + 1)'(MAX_VERTICES);
	localparam logic [PW-1:0]     PLIM = PW'(MAX_VERTICES);

	// stores
	logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
	logic [VERTEX_W-1:0]     fst_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] row_vld_q;

	// control and working registers
	state_t                  state_q;
	logic                    mode_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [PW-1:0]           head_q;
	logic [PW-1:0]           tail_q;
	logic [MAX_VERTICES-1:0] succ_q;
	logic [VERTEX_W-1:0]     v_q;
	logic                    err_q;
	logic [VAW-1:0]          src_q;
	logic [VAW-1:0]          dst_q;
	logic [MAX_VERTICES-1:0] adj_rd_q;
	logic                    rvld_rd_q;
	logic [VERTEX_W-1:0]     fst_rd_q;

	// output register
	logic                    m_valid_q;
	logic [VERTEX_W-1:0]     m_vertex_q;
	logic                    m_more_q;
	logic                    m_err_q;

	// decoded input fields
	opcode_t             op;
	logic [VERTEX_W-1:0] src_f;
	logic [VERTEX_W-1:0] dst_f;
	logic                accept;
	logic                src_ok;
	logic                dst_ok;
	logic                nonempty;

	// memory port control
	logic                adj_ren;
	logic [VAW-1:0]      adj_raddr;
	logic                fst_we;
	logic [VAW-1:0]      fst_waddr;
	logic [VERTEX_W-1:0] fst_wdata;
	logic                fst_ren;
	logic [VAW-1:0]      fst_raddr;

	// shared lowest-set-bit encoder
	logic [MAX_VERTICES-1:0] low_bit;
	logic [VAW-1:0]          low_idx;
	logic                    can_push;
	logic                    out_free;
	logic                    cfg_wr;

	assign op       = opcode_t'(s_tuser);
	assign src_f    = s_tdata[VERTEX_W-1:0];
	assign dst_f    = s_tdata[2*VERTEX_W-1:VERTEX_W];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign src_ok   = {1'b0, src_f} < VLIM;
	assign dst_ok   = {1'b0, dst_f} < VLIM;
	assign nonempty = head_q < tail_q;
	assign can_push = tail_q < PLIM;
	assign out_free = !m_valid_q || m_tready;

	// isolate the lowest pending successor, then encode its index
	assign low_bit = succ_q & (~succ_q + MAX_VERTICES'(1));
	always_comb begin
		low_idx = '0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			if (low_bit[i]) begin
				low_idx = low_idx | VAW'(i);
			end
		end
	end

	// memory port selection
	always_comb begin
		adj_ren   = 1'b0;
		adj_raddr = src_f[VAW-1:0];
		fst_ren   = 1'b0;
		fst_raddr = head_q[VAW-1:0];
		fst_we    = 1'b0;
		fst_waddr = tail_q[VAW-1:0];
		fst_wdata = VERTEX_W'(low_idx);
		case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_ADD_EDGE) begin
					adj_ren = 1'b1;
				end
				if (accept && op == OP_NEXT) begin
					fst_ren = 1'b1;
					// dfs pops the newest entry, bfs the oldest
					if (mode_q) begin
						fst_raddr = VAW'(tail_q - PW'(1));
					end
				end
				if (accept && op == OP_START && src_ok) begin
					fst_we    = 1'b1;
					fst_waddr = '0;
					fst_wdata = src_f;
				end
			end
			ST_POP: begin
				adj_ren   = 1'b1;
				adj_raddr = fst_rd_q[VAW-1:0];
			end
			ST_SCAN: begin
				fst_we = (succ_q != '0) && can_push;
			end
			default: begin
			end
		endcase
	end

	// adjacency matrix: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (state_q == ST_EDGE) begin
			adj_mem[src_q] <= (rvld_rd_q ? adj_rd_q : '0) | (MAX_VERTICES'(1) << dst_q);
		end
		if (adj_ren) begin
			adj_rd_q  <= adj_mem[adj_raddr];
			rvld_rd_q <= row_vld_q[adj_raddr];
		end
	end

	// frontier store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (fst_we) begin
			fst_mem[fst_waddr] <= fst_wdata;
		end
		if (fst_ren) begin
			fst_rd_q <= fst_mem[fst_raddr];
		end
	end

	// row valid bits: a row not yet written since reset or clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (accept && op == OP_CLEAR) begin
			row_vld_q <= '0;
		end else if (state_q == ST_EDGE) begin
			row_vld_q[src_q] <= 1'b1;
		end
	end

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_MODE_ADDR);
	assign prdata = (paddr == REG_MODE_ADDR) ? {{(APB_DW-1){1'b0}}, mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_wr) begin
			mode_q <= pwdata[0];
		end
	end

	// operand capture for the multi-cycle commands
	always_ff @(posedge clk) begin
		if (accept) begin
			src_q <= src_f[VAW-1:0];
			dst_q <= dst_f[VAW-1:0];
		end
		if (state_q == ST_POP) begin
			v_q <= fst_rd_q;
		end
	end

	// sequencer, traversal state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			visited_q  <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			succ_q     <= '0;
			err_q      <= 1'b0;
			m_valid_q  <= 1'b0;
			m_vertex_q <= '0;
			m_more_q   <= 1'b0;
			m_err_q    <= 1'b0;
		end else begin
			// the emit state reloads the output register itself
			if (m_valid_q && m_tready && state_q != ST_EMIT) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op)
							OP_ADD_EDGE: begin
								if (src_ok && dst_ok) begin
									state_q <= ST_EDGE;
								end
							end
							OP_START: begin
								head_q <= '0;
								if (src_ok) begin
									tail_q    <= PW'(1);
									visited_q <= MAX_VERTICES'(1) << src_f[VAW-1:0];
								end else begin
									tail_q    <= '0;
									visited_q <= '0;
								end
							end
							OP_NEXT: begin
								if (nonempty) begin
									err_q   <= 1'b0;
									state_q <= ST_POP;
									if (mode_q) begin
										tail_q <= tail_q - PW'(1);
									end else begin
										head_q <= head_q + PW'(1);
									end
								end else begin
									err_q   <= 1'b1;
									state_q <= ST_EMIT;
								end
							end
							default: begin
								// clear touches only the row valid bits
							end
						endcase
					end
				end
				ST_EDGE: begin
					state_q <= ST_IDLE;
				end
				ST_POP: begin
					state_q <= ST_ROW;
				end
				ST_ROW: begin
					succ_q  <= (rvld_rd_q ? adj_rd_q : '0) & ~visited_q;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (succ_q == '0) begin
						state_q <= ST_EMIT;
					end else begin
						// one successor per cycle, ascending index
						visited_q <= visited_q | low_bit;
						succ_q    <= succ_q & ~low_bit;
						if (can_push) begin
							tail_q <= tail_q + PW'(1);
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_valid_q  <= 1'b1;
						m_vertex_q <= err_q ? '0 : v_q;
						m_more_q   <= !err_q && nonempty;
						m_err_q    <= err_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(M_DATA_W-VERTEX_W){1'b0}}, m_vertex_q};
	assign m_tuser  = {m_err_q, m_more_q};

	// checks on the traversal logic
	`GTB_ASSERT_NOW(a_ptr_order, clk, arst_n, 1'b1,
		(head_q <= tail_q) && (tail_q <= PLIM), "frontier pointers out of order")
	`GTB_ASSERT_NEXT(a_scan_one, clk, arst_n, (state_q == ST_SCAN) && (succ_q != '0),
		$countones(succ_q) == $countones($past(succ_q)) - 1, "scan did not retire one successor")
	`GTB_ASSERT_NEXT(a_emit_load, clk, arst_n, (state_q == ST_EMIT) && out_free,
		m_tvalid && (state_q == ST_IDLE), "result not loaded on emit")
	`GTB_ASSERT_NOW(a_err_clean, clk, arst_n, m_tvalid && m_tuser[1],
		(m_tuser[0] == 1'b0) && (m_tdata == '0), "error result carries data")

endmodule
